@@ rtl/ovi_pkg.sv @@
// shared types and constants for the octree voxel insert block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ovi_pkg;

  // tree shape and store size (NODE_SLOTS must be a power of two)
  localparam int DEPTH      = 4;
  localparam int NODE_SLOTS = 4096;

  localparam int SLOT_W  = $clog2(NODE_SLOTS);
  localparam int FP_W    = SLOT_W + 1;
  localparam int LVL_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = FP_W + 3;
  localparam int COORD_W = 8;
  localparam int VAL_W   = 16;
  localparam int SIZE_W  = 9;
  localparam int LEAF_W  = 12;
  localparam int ADD_W   = 5;
  localparam int MASK_W  = 8;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic [SIZE_W-1:0] GRID_MAX  = SIZE_W'(1 << DEPTH);
  localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(16);
  localparam logic [SLOT_W-1:0] ROOT_SLOT = '0;
  localparam logic [SLOT_W-1:0] ROOT_BASE = SLOT_W'(1);
  localparam logic [FP_W-1:0]   FP_RESET  = FP_W'(9);
  localparam logic [FP_W-1:0]   BLOCK_FP  = FP_W'(8);
  localparam logic [ADD_W-1:0]  BLOCK_ADD = ADD_W'(8);

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OOB  = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [VAL_W-1:0]   voxel_value;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [LEAF_W-1:0]  leaf_slot;
    logic [ADD_W-1:0]   slots_added;
  } out_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] child_mask;
    logic [SLOT_W-1:0] child_base;
    logic [VAL_W-1:0]  leaf_value;
  } node_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    node_entry_t       data;
  } mem_wr_t;

endpackage

@@ rtl/ovi_node_store.sv @@
// node store: one entry per slot holding child mask, child base and leaf value
// depends on ovi_pkg; one write port, one registered read port
`timescale 1ns / 1ps

module ovi_node_store
  import ovi_pkg::*;
(
  input  logic        clk,
  input  mem_rd_t     rd,
  input  mem_wr_t     wr,
  output node_entry_t rd_data
);

  node_entry_t mem [NODE_SLOTS];
  node_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/ovi_walk.sv @@
// tree walk sequencer: clearing pass, lookup walk, store-full check, write-back walk
// depends on ovi_pkg; drives the ports of ovi_node_store
`timescale 1ns / 1ps

module ovi_walk
  import ovi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_word_t    item,
  input  logic        item_oob,
  output logic        res_valid,
  input  logic        res_ready,
  output out_word_t   res,
  output mem_rd_t     mem_rd,
  output mem_wr_t     mem_wr,
  input  node_entry_t mem_rdata
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_WRITE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t             state_r,    state_nxt;
  logic [SLOT_W-1:0]  clr_r,      clr_nxt;
  logic [COORD_W-1:0] xs_r,       xs_nxt;
  logic [COORD_W-1:0] ys_r,       ys_nxt;
  logic [COORD_W-1:0] zs_r,       zs_nxt;
  logic [VAL_W-1:0]   val_r,      val_nxt;
  logic [SLOT_W-1:0]  node_r,     node_nxt;
  logic [LVL_W-1:0]   d_r,        d_nxt;
  logic [SLOT_W-1:0]  cur_r,      cur_nxt;
  logic [MASK_W-1:0]  cur_mask_r, cur_mask_nxt;
  logic [SLOT_W-1:0]  cur_base_r, cur_base_nxt;
  logic [FP_W-1:0]    fp_r,       fp_nxt;
  logic [ADD_W-1:0]   added_r,    added_nxt;
  status_t            status_r,   status_nxt;

  logic [2:0]         code;
  logic [MASK_W-1:0]  code_bit;
  logic [SLOT_W-1:0]  base_look;
  logic [SLOT_W-1:0]  child_look;
  logic [SLOT_W-1:0]  child_wr;
  logic [LVL_W-1:0]   needed;
  logic [SUM_W-1:0]   fp_end;
  logic               present;
  logic               full;
  logic               last_lvl;
  logic               at_leaf;

  // child number from the current top bit of each coordinate
  assign code     = {xs_r[DEPTH-1], ys_r[DEPTH-1], zs_r[DEPTH-1]};
  assign code_bit = MASK_W'(1) << code;

  assign base_look  = (node_r == ROOT_SLOT) ? ROOT_BASE : mem_rdata.child_base;
  assign child_look = base_look + SLOT_W'(code);
  assign child_wr   = cur_base_r + SLOT_W'(code);
  assign present    = mem_rdata.child_mask[code];
  assign last_lvl   = (d_r == LVL_W'(DEPTH - 1));
  assign at_leaf    = (d_r == LVL_W'(DEPTH));

  // inner nodes still to create below the first missing level
  assign needed = LVL_W'(DEPTH - 1) - d_r;
  assign fp_end = SUM_W'(fp_r) + (SUM_W'(needed) << 3);
  assign full   = (fp_end > SUM_W'(NODE_SLOTS));

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    xs_nxt       = xs_r;
    ys_nxt       = ys_r;
    zs_nxt       = zs_r;
    val_nxt      = val_r;
    node_nxt     = node_r;
    d_nxt        = d_r;
    cur_nxt      = cur_r;
    cur_mask_nxt = cur_mask_r;
    cur_base_nxt = cur_base_r;
    fp_nxt       = fp_r;
    added_nxt    = added_r;
    status_nxt   = status_r;
    mem_rd       = '0;
    mem_wr       = '0;

    case (state_r)
      S_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = clr_r;
        clr_nxt     = clr_r + SLOT_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          xs_nxt    = item.x;
          ys_nxt    = item.y;
          zs_nxt    = item.z;
          val_nxt   = item.voxel_value;
          added_nxt = '0;
          d_nxt     = '0;
          node_nxt  = ROOT_SLOT;
          cur_nxt   = ROOT_SLOT;
          if (item_oob) begin
            status_nxt = STATUS_OOB;
            state_nxt  = S_RESP;
          end else begin
            mem_rd.en   = 1'b1;
            mem_rd.addr = ROOT_SLOT;
            state_nxt   = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (present) begin
          if (last_lvl) begin
            cur_nxt   = child_look;
            d_nxt     = LVL_W'(DEPTH);
            state_nxt = S_WRITE;
          end else begin
            mem_rd.en   = 1'b1;
            mem_rd.addr = child_look;
            node_nxt    = child_look;
            d_nxt       = d_r + LVL_W'(1);
            xs_nxt      = {xs_r[COORD_W-2:0], 1'b0};
            ys_nxt      = {ys_r[COORD_W-2:0], 1'b0};
            zs_nxt      = {zs_r[COORD_W-2:0], 1'b0};
          end
        end else if (full) begin
          status_nxt = STATUS_FULL;
          state_nxt  = S_RESP;
        end else begin
          cur_nxt      = node_r;
          cur_mask_nxt = mem_rdata.child_mask;
          cur_base_nxt = base_look;
          state_nxt    = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = cur_r;
        if (at_leaf) begin
          mem_wr.data.leaf_value = val_r;
          status_nxt             = STATUS_OK;
          state_nxt              = S_RESP;
        end else begin
          // parent gets its new child bit; a fresh node's mask is written once, final
          mem_wr.data.child_mask = cur_mask_r | code_bit;
          mem_wr.data.child_base = cur_base_r;
          cur_nxt      = child_wr;
          cur_mask_nxt = '0;
          if (!last_lvl) begin
            cur_base_nxt = fp_r[SLOT_W-1:0];
            fp_nxt       = fp_r + BLOCK_FP;
            added_nxt    = added_r + BLOCK_ADD;
          end
          d_nxt  = d_r + LVL_W'(1);
          xs_nxt = {xs_r[COORD_W-2:0], 1'b0};
          ys_nxt = {ys_r[COORD_W-2:0], 1'b0};
          zs_nxt = {zs_r[COORD_W-2:0], 1'b0};
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      fp_r    <= FP_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      fp_r    <= fp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xs_r       <= xs_nxt;
    ys_r       <= ys_nxt;
    zs_r       <= zs_nxt;
    val_r      <= val_nxt;
    node_r     <= node_nxt;
    d_r        <= d_nxt;
    cur_r      <= cur_nxt;
    cur_mask_r <= cur_mask_nxt;
    cur_base_r <= cur_base_nxt;
    added_r    <= added_nxt;
    status_r   <= status_nxt;
  end

  assign item_ready      = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_RESP);
  assign res.status      = status_r;
  assign res.leaf_slot   = (status_r == STATUS_OK) ? LEAF_W'(cur_r) : '0;
  assign res.slots_added = (status_r == STATUS_OK) ? added_r : '0;

  // allocation never runs past the end of the store
  a_fp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fp_r <= FP_W'(NODE_SLOTS))
    else $error("free pointer beyond node store");

  // the free pointer moves only on a write-back step
  a_fp_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r != S_WRITE) |=> $stable(fp_r))
    else $error("free pointer changed outside write-back");

  // a lookup step always consumes a read issued the cycle before
  a_look_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> $past(mem_rd.en))
    else $error("lookup without a preceding store read");

  // a written leaf is never the root slot
  a_leaf_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && status_r == STATUS_OK) |-> (cur_r != ROOT_SLOT))
    else $error("leaf slot resolved to root");

endmodule

@@ rtl/octree_voxel_insert.sv @@
// top level of the octree voxel insert block: config registers, bounds check, result register
// depends on ovi_pkg, ovi_node_store and ovi_walk
`timescale 1ns / 1ps

// Sets one voxel of a sparse octree per input word. The coordinates are checked
// against the grid size registers (clamped to two to the DEPTH); a failing word
// returns status out-of-bounds with no store access. Otherwise the walk reads the
// node store once for each node on the path down to the first missing child, then
// writes the parent of that child, each new node below it and the leaf, and then
// hands the result word to the output register. A word that would need more slots
// than the store has left returns status full with no writes. The node store has
// a single read and a single write port and every level depends on the entry read
// for the level above, so words are handled one at a time. After reset the block
// clears the child mask of all NODE_SLOTS (4096) slots, one slot per cycle, before
// in_ready rises; config writes are taken during that pass. The output register
// lets the next word enter while a result waits on out_ready.
module octree_voxel_insert
  import ovi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // voxel write words
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  // config port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [SIZE_W-1:0] size_x_r, size_x_nxt;
  logic [SIZE_W-1:0] size_y_r, size_y_nxt;
  logic [SIZE_W-1:0] size_z_r, size_z_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r,  out_data_nxt;

  cfg_reg_t          cfg_idx;
  logic              cfg_wr;
  logic              oob;
  logic              res_valid;
  logic              res_ready;
  out_word_t         res;
  mem_rd_t           mem_rd;
  mem_wr_t           mem_wr;
  node_entry_t       mem_rdata;

  // config registers, word address selects the register
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    size_x_nxt = size_x_r;
    size_y_nxt = size_y_r;
    size_z_nxt = size_z_r;
    cfg_prdata = '0;
    case (cfg_idx)
      REG_SIZE_X: begin
        cfg_prdata = CFG_DW'(size_x_r);
        if (cfg_wr) size_x_nxt = cfg_pwdata[SIZE_W-1:0];
      end
      REG_SIZE_Y: begin
        cfg_prdata = CFG_DW'(size_y_r);
        if (cfg_wr) size_y_nxt = cfg_pwdata[SIZE_W-1:0];
      end
      REG_SIZE_Z: begin
        cfg_prdata = CFG_DW'(size_z_r);
        if (cfg_wr) size_z_nxt = cfg_pwdata[SIZE_W-1:0];
      end
      default: begin
        // unmapped word address: reads zero, writes dropped
        cfg_prdata = '0;
      end
    endcase
  end

  // bounds check: limit is the smaller of the size register and the tree extent
  function automatic logic coord_ok(input logic [COORD_W-1:0] c,
                                    input logic [SIZE_W-1:0]  size);
    logic [SIZE_W-1:0] lim;
    lim = (size > GRID_MAX) ? GRID_MAX : size;
    return (SIZE_W'(c) < lim);
  endfunction

  assign oob = !(coord_ok(in_data.x, size_x_r) &&
                 coord_ok(in_data.y, size_y_r) &&
                 coord_ok(in_data.z, size_z_r));

  ovi_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (in_data),
    .item_oob   (oob),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_rd     (mem_rd),
    .mem_wr     (mem_wr),
    .mem_rdata  (mem_rdata)
  );

  ovi_node_store u_store (
    .clk     (clk),
    .rd      (mem_rd),
    .wr      (mem_wr),
    .rd_data (mem_rdata)
  );

  // output register, refilled as soon as the current word leaves
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r    <= SIZE_RST;
      size_y_r    <= SIZE_RST;
      size_z_r    <= SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      size_x_r    <= size_x_nxt;
      size_y_r    <= size_y_nxt;
      size_z_r    <= size_z_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/ovi_insert_checker.sv @@
// result checker for the octree voxel insert block: follows size register writes,
// predicts each result word from a private node store and compares; needs ovi_pkg
`timescale 1ns / 1ps

module ovi_insert_checker
  import ovi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_word_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_word_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                fail_count,
  output int                pending
);

  localparam int BLOCK_SLOTS = 8;

  logic [MASK_W-1:0] mask_mem [NODE_SLOTS];
  logic [SLOT_W-1:0] base_mem [NODE_SLOTS];
  logic [VAL_W-1:0]  leaf_mem [NODE_SLOTS];
  int unsigned       free_ptr;
  logic [SLOT_W-1:0] root_base;
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  out_word_t         result_q [$];
  int                fails = 0;

  function automatic logic fits(input logic [COORD_W-1:0] c, input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] lim;
    lim = (sz < GRID_MAX) ? sz : GRID_MAX;
    return SIZE_W'(c) < lim;
  endfunction

  // child number at a level: one bit of each coordinate, msb first
  function automatic logic [2:0] octant(input in_word_t w, input int lvl);
    int sh;
    sh = DEPTH - lvl - 1;
    return {w.x[sh], w.y[sh], w.z[sh]};
  endfunction

  function automatic logic [SLOT_W-1:0] child_of(input logic [SLOT_W-1:0] node,
                                                 input logic [2:0] c);
    logic [SLOT_W-1:0] b;
    b = (node == ROOT_SLOT) ? root_base : base_mem[node];
    return b + SLOT_W'(c);
  endfunction

  function automatic out_word_t insert_voxel(input in_word_t w);
    out_word_t         r;
    logic [SLOT_W-1:0] node, child;
    logic [2:0]        c;
    int                found, needed;
    int unsigned       added;
    r = '0;
    r.status = STATUS_OK;
    if (!fits(w.x, size_x) || !fits(w.y, size_y) || !fits(w.z, size_z)) begin
      r.status = STATUS_OOB;
      return r;
    end
    // look-ahead: how many inner nodes this word would create
    node = ROOT_SLOT;
    found = 0;
    while (found < DEPTH && mask_mem[node][octant(w, found)]) begin
      node = child_of(node, octant(w, found));
      found++;
    end
    needed = (found < DEPTH - 1) ? DEPTH - 1 - found : 0;
    if (free_ptr + BLOCK_SLOTS * needed > NODE_SLOTS) begin
      r.status = STATUS_FULL;
      return r;
    end
    node = ROOT_SLOT;
    added = 0;
    for (int lvl = 0; lvl < DEPTH; lvl++) begin
      c = octant(w, lvl);
      child = child_of(node, c);
      if (!mask_mem[node][c]) begin
        mask_mem[child] = '0;
        if (lvl + 1 < DEPTH) begin
          base_mem[child] = free_ptr[SLOT_W-1:0];
          free_ptr += BLOCK_SLOTS;
          added += BLOCK_SLOTS;
        end
        mask_mem[node][c] = 1'b1;
      end
      node = child;
    end
    leaf_mem[node] = w.voxel_value;
    r.leaf_slot = LEAF_W'(node);
    r.slots_added = ADD_W'(added);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < NODE_SLOTS; i++) begin
        mask_mem[i] = '0;
        base_mem[i] = '0;
        leaf_mem[i] = '0;
      end
      free_ptr = 32'(FP_RESET);
      root_base = ROOT_BASE;
      size_x = SIZE_RST;
      size_y = SIZE_RST;
      size_z = SIZE_RST;
      result_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_reg_t'(cfg_paddr[CFG_AW-1:2]))
          REG_SIZE_X: size_x = cfg_pwdata[SIZE_W-1:0];
          REG_SIZE_Y: size_y = cfg_pwdata[SIZE_W-1:0];
          REG_SIZE_Z: size_z = cfg_pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        result_q.insert(result_q.size(), insert_voxel(in_data));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word: status %0d leaf %0d added %0d",
                   $time, out_data.status, out_data.leaf_slot, out_data.slots_added);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (out_data.status !== want.status || out_data.leaf_slot !== want.leaf_slot ||
              out_data.slots_added !== want.slots_added) begin
            $display("%0t: expected status %0d leaf %0d added %0d, got status %0d leaf %0d added %0d",
                     $time, want.status, want.leaf_slot, want.slots_added,
                     out_data.status, out_data.leaf_slot, out_data.slots_added);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending <= result_q.size();
  end

endmodule

@@ sim/tb_octree_voxel_insert.sv @@
// testbench top for the octree voxel insert block: clock, reset, stimulus and verdict
// depends on ovi_pkg, octree_voxel_insert and ovi_insert_checker
`timescale 1ns / 1ps

module tb_octree_voxel_insert;
  import ovi_pkg::*;

  localparam int QUIET_LIMIT  = 20000;  // covers the clearing pass and long stalls
  localparam int RANDOM_WORDS = 270;    // per random phase
  localparam int SETTLE       = 20;     // cycles after the last result
  localparam logic [1:0] REG_UNUSED = 2'd3;  // index past the last size register

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending;
  int quiet = 0;

  // idle rates in percent: sender gaps and receiver stalls
  int send_idle_pct = 0;
  int stall_pct = 0;
  int fresh_pct = 0;

  // usable extent per axis under the current size registers
  int ext_x = 16, ext_y = 16, ext_z = 16;

  // lowest inner cubes already aimed at, so fresh picks keep allocating blocks
  logic seen_cube [1 << (3 * (DEPTH - 1))];

  octree_voxel_insert dut (.*);

  ovi_insert_checker insert_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls on out_ready
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  // watchdog: nothing accepted on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // apb write: setup then access; psel is left high for a following write
  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'({idx, 2'b00});
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic cfg_release();
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic int extent(input int sz);
    return (sz < (1 << DEPTH)) ? sz : (1 << DEPTH);
  endfunction

  task automatic set_grid(input int sx, input int sy, input int sz);
    cfg_write(REG_SIZE_X, sx);
    cfg_write(REG_SIZE_Y, sy);
    cfg_write(REG_SIZE_Z, sz);
    cfg_release();
    ext_x = extent(sx);
    ext_y = extent(sy);
    ext_z = extent(sz);
  endtask

  // one word on the input channel; valid stays up between back-to-back words
  task automatic send_word(input in_word_t w);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender pause until every expected result word is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input int ext);
    return (ext == 0) ? COORD_W'($urandom_range(255)) : COORD_W'($urandom_range(ext - 1));
  endfunction

  // mostly in-grid writes, some aimed at untouched subtrees; the rest full-range noise
  function automatic in_word_t random_word();
    in_word_t                    w;
    int                          tries;
    logic [3*(DEPTH-1)-1:0]      cube;
    w.voxel_value = VAL_W'($urandom);
    if ($urandom_range(99) < 15) begin
      w.x = COORD_W'($urandom_range(255));
      w.y = COORD_W'($urandom_range(255));
      w.z = COORD_W'($urandom_range(255));
    end else begin
      tries = ($urandom_range(99) < fresh_pct) ? 12 : 1;
      do begin
        w.x = pick_coord(ext_x);
        w.y = pick_coord(ext_y);
        w.z = pick_coord(ext_z);
        cube = {w.x[DEPTH-1:1], w.y[DEPTH-1:1], w.z[DEPTH-1:1]};
        tries--;
      end while (tries > 0 && seen_cube[cube]);
      seen_cube[cube] = 1'b1;
    end
    return w;
  endfunction

  initial begin
    for (int i = 0; i < (1 << (3 * (DEPTH - 1))); i++)
      seen_cube[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed grid: y above two to the depth with junk in the upper bits, z short,
    // plus a write to the unused index that must change nothing
    cfg_write(REG_SIZE_X, 32'd16);
    cfg_write(REG_SIZE_Y, 32'hFFFF_FF00);
    cfg_write(REG_SIZE_Z, 32'd10);
    cfg_write(REG_UNUSED, 32'd3);
    cfg_release();
    ext_x = 16;
    ext_y = 16;
    ext_z = 10;

    send_word({8'd0, 8'd0, 8'd0, 16'h0000});    // new path from the root, three blocks
    send_word({8'd0, 8'd0, 8'd0, 16'hFFFF});    // rewrite of an existing leaf
    send_word({8'd1, 8'd0, 8'd0, 16'h1234});    // sibling leaf, nothing allocated
    send_word({8'd2, 8'd0, 8'd0, 16'h5678});    // one new block at the last inner level
    send_word({8'd15, 8'd15, 8'd9, 16'h8000});  // top corner of the grid
    // every child number under the root
    for (int c = 0; c < 8; c++)
      send_word({c[2] ? 8'd8 : 8'd0, c[1] ? 8'd8 : 8'd0, c[0] ? 8'd8 : 8'd0,
                 16'(c * 16'h2491)});
    // out of bounds on each axis, including the clamp of an oversized y
    send_word({8'd16, 8'd0, 8'd0, 16'h0001});
    send_word({8'd255, 8'd255, 8'd255, 16'hFFFF});
    send_word({8'd0, 8'd16, 8'd0, 16'h0002});
    send_word({8'd0, 8'd255, 8'd0, 16'h0003});
    send_word({8'd0, 8'd0, 8'd10, 16'h0004});
    send_word({8'd0, 8'd0, 8'd255, 16'h0005});

    // zero size on y: nothing is in the grid
    drain();
    cfg_write(REG_SIZE_Y, 32'd0);
    cfg_release();
    ext_y = 0;
    send_word({8'd0, 8'd0, 8'd0, 16'hAAAA});
    send_word({8'd7, 8'd0, 8'd5, 16'h5555});

    // random phases, each with its own grid and idle pattern
    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin
          set_grid(16, 16, 16);
          send_idle_pct = 0;
          stall_pct <= 0;
          fresh_pct = 30;
        end
        1: begin
          set_grid(256, 200, 511);
          send_idle_pct = 79;
          stall_pct <= 0;
          fresh_pct = 30;
        end
        2: begin
          set_grid(1, 16, 9);
          send_idle_pct = 0;
          stall_pct <= 79;
          fresh_pct = 0;
        end
        default: begin
          // fill the store until writes start coming back full
          set_grid(16, 16, 16);
          send_idle_pct = 20;
          stall_pct <= 20;
          fresh_pct = 60;
        end
      endcase
      repeat (RANDOM_WORDS) send_word(random_word());
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
